[hw/rtl/zero_skipping_gaussian_blur_macros.svh]
// ----------------------------------------------------------------------------
// zero skipping gaussian blur assertion macros
// shared property forms for the checker of the blur block
// ----------------------------------------------------------------------------
`ifndef ZERO_SKIPPING_GAUSSIAN_BLUR_MACROS_SVH
`define ZERO_SKIPPING_GAUSSIAN_BLUR_MACROS_SVH

// same-cycle implication
`define ZSGB_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define ZSGB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hw/rtl/zsgb_pkg.sv]
// ----------------------------------------------------------------------------
// zsgb_pkg
// field widths, action and register codes, and the gaussian weight table
// ----------------------------------------------------------------------------
package zsgb_pkg;

   localparam int PIXEL_W       = 8;
   localparam int WEIGHT_W      = 16;
   localparam int PIXEL_INDEX_W = 16;
   localparam int ACTION_W      = 2;
   localparam int CFG_W         = 9;
   localparam int CSR_INDEX_W   = 2;
   localparam int CHANNELS_W    = 3;
   localparam int RADIUS_CFG_W  = 4;
   localparam int DIV_CNT_W     = $clog2(PIXEL_W);

   // action codes
   localparam logic [ACTION_W-1:0] ACT_LOAD = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_RUN  = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_READ = 2'd2;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_WIDTH    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_HEIGHT   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_CHANNELS = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_RADIUS   = 2'd3;

   localparam logic [CFG_W-1:0]        WIDTH_RESET    = 9'd256;
   localparam logic [CFG_W-1:0]        HEIGHT_RESET   = 9'd256;
   localparam logic [CHANNELS_W-1:0]   CHANNELS_RESET = 3'd1;
   localparam logic [RADIUS_CFG_W-1:0] RADIUS_RESET   = 4'd2;

   localparam logic [CHANNELS_W-1:0] FOUR_CHANNELS = 3'd4;
   localparam logic [PIXEL_W-1:0]    ALPHA_OPAQUE  = 8'hFF;

   // exp(-1/32) in q0.32
   localparam logic [31:0] EXP_STEP = 32'd4162825044;

   // weights are zero from squared distance 378 on, so the table stops short
   localparam int WROM_DEPTH = 384;
   localparam int WROM_IDX_W = $clog2(WROM_DEPTH);

   typedef logic [WEIGHT_W-1:0] weight_rom_type [WROM_DEPTH];

   // w(d) = round(exp(-d/32)) in q0.16, saturated, by exact recurrence in q0.32
   function automatic weight_rom_type build_weight_rom();
      weight_rom_type rom;
      logic [95:0]    v;
      logic [95:0]    w;
      v = 96'd1 << 32;
      for (int d = 0; d < WROM_DEPTH; d++) begin
         w = (v + 96'd32768) >> 16;
         rom[d] = (w > 96'd65535) ? 16'hFFFF : w[WEIGHT_W-1:0];
         v = (v * 96'(EXP_STEP) + (96'd1 << 31)) >> 32;
      end
      return rom;
   endfunction

   localparam weight_rom_type WEIGHT_ROM = build_weight_rom();

endpackage

[hw/rtl/zsgb_ram.sv]
// ----------------------------------------------------------------------------
// zsgb_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module zsgb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 65536
) (
   input  logic                                         clock,
   input  logic                                         write_enable,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] write_address,
   input  logic [WIDTH-1:0]                             write_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] read_address,
   output logic [WIDTH-1:0]                             read_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem[write_address] <= write_data;
      end
      rd_data_ff <= mem[read_address];
   end

   assign read_data = rd_data_ff;

endmodule

[hw/rtl/zero_skipping_gaussian_blur.sv]
// ----------------------------------------------------------------------------
// zero_skipping_gaussian_blur
// in-place normalized gaussian blur of a byte image with zero pixels skipped
// ----------------------------------------------------------------------------
// Holds one channel-0 byte image of up to MAX_WIDTH x MAX_HEIGHT pixels in an
// on-chip ram. A load word stores a byte and echoes it, a read word returns
// the stored byte, and a run word blurs the whole image in place in raster
// order, so each pixel sees the already blurred values of earlier pixels.
// Each new value is floor(sum(v*w)/sum(w)) over the nonzero pixels of the
// (2r+1)x(2r+1) window, window positions taken as flat raster indices clamped
// to the image, w = exp(-(dx*dx+dy*dy)/32) in q0.16; an empty sum gives 0.
// Alpha reads 255 when channel_count is four, otherwise it equals the value.
// A load is answered from its own byte, a read from the registered ram read.
// In a run the single ram read port fetches one window tap per cycle;
// for every pixel the fetch/weight/multiply/accumulate pipe then drains,
// an 8-step restoring divider runs and the result is written back. A run
// with zero width or height is answered without a pass. Only one word is
// in flight at a time; req_stall stays high until its result word is in
// the output register. There is no clearing pass: pixels never loaded
// read back as undefined.
// ----------------------------------------------------------------------------
module zero_skipping_gaussian_blur
   import zsgb_pkg::*;
#(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256,
   parameter int MAX_RADIUS = 15
) (
   input  logic                     clock,
   input  logic                     reset,
   // request channel
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [ACTION_W-1:0]      req_action,
   input  logic [PIXEL_INDEX_W-1:0] req_pixel_index,
   input  logic [PIXEL_W-1:0]       req_pixel_value,
   // response channel
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [PIXEL_W-1:0]       rsp_result_value,
   output logic [PIXEL_W-1:0]       rsp_result_alpha,
   // register write port
   input  logic                     csr_write_enable,
   input  logic [CSR_INDEX_W-1:0]   csr_index,
   input  logic [CFG_W-1:0]         csr_write_data
);

   // geometry of storage and datapath
   localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
   localparam int IDX_W       = (ADDR_W > PIXEL_INDEX_W) ? ADDR_W : PIXEL_INDEX_W;
   localparam int EW_W        = $clog2(MAX_WIDTH + 1);
   localparam int EH_W        = $clog2(MAX_HEIGHT + 1);
   localparam int R_W         = $clog2(MAX_RADIUS + 1);
   localparam int MB_W        = (EH_W > R_W) ? EH_W : R_W;
   localparam int MP_W        = EW_W + MB_W;
   localparam int SV_W        = R_W + 1;
   localparam int D_W         = $clog2(2 * MAX_RADIUS * MAX_RADIUS + 1);
   localparam int WIN_TAPS    = (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1);
   localparam int DEN_W       = WEIGHT_W + $clog2(WIN_TAPS);
   localparam int NUM_W       = DEN_W + PIXEL_W;
   localparam int PROD_W      = PIXEL_W + WEIGHT_W;
   localparam int FI_W        =
      $clog2((MAX_HEIGHT + MAX_RADIUS + 1) * MAX_WIDTH + MAX_RADIUS + 1) + 1;

   typedef enum logic [8:0] {
      S_IDLE     = 9'b000000001,
      S_READ     = 9'b000000010,
      S_MUL_AREA = 9'b000000100,
      S_MUL_RAD  = 9'b000001000,
      S_WINDOW   = 9'b000010000,
      S_SCAN     = 9'b000100000,
      S_DRAIN    = 9'b001000000,
      S_DIVIDE   = 9'b010000000,
      S_WRITE    = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   // configuration
   logic [CFG_W-1:0]        width_ff, height_ff;
   logic [CHANNELS_W-1:0]   chan_ff;
   logic [RADIUS_CFG_W-1:0] radius_ff;

   // output register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [PIXEL_W-1:0] rsp_value_ff, rsp_alpha_ff;
   logic               rsp_load;
   logic [PIXEL_W-1:0] rsp_new;

   // sequencer registers
   logic                    rd_oob_ff, rd_oob_in;
   logic [EW_W-1:0]         x_ff, x_in;
   logic [EH_W-1:0]         y_ff, y_in;
   logic [ADDR_W-1:0]       ybase_ff, ybase_in;
   logic [ADDR_W-1:0]       last_ff, last_in;
   logic signed [FI_W-1:0]  rw_ff, rw_in;
   logic signed [SV_W-1:0]  sx_ff, sx_in, sy_ff, sy_in;
   logic signed [FI_W-1:0]  row_ff, row_in, col_ff, col_in;
   logic [NUM_W-1:0]        num_ff, num_in;
   logic [DEN_W-1:0]        den_ff, den_in;
   logic                    acc_done_ff, acc_done_in;
   logic [NUM_W-1:0]        rem_ff, rem_in, dsr_ff, dsr_in;
   logic [PIXEL_W-1:0]      quo_ff, quo_in;
   logic [DIV_CNT_W-1:0]    div_cnt_ff, div_cnt_in;

   // tap pipeline: fetch, weight, multiply
   logic                a_valid_ff, a_last_ff;
   logic [D_W-1:0]      d_ff;
   logic                b_valid_ff, b_last_ff;
   logic [PIXEL_W-1:0]  b_val_ff;
   logic [WEIGHT_W-1:0] b_w_ff;
   logic                c_valid_ff, c_last_ff;
   logic [PROD_W-1:0]   c_prod_ff;
   logic [WEIGHT_W-1:0] c_w_ff;

   // combinational helpers
   logic [EW_W-1:0]           eff_w;
   logic [EH_W-1:0]           eff_h;
   logic [R_W-1:0]            eff_r;
   logic signed [SV_W-1:0]    r_s;
   logic signed [FI_W-1:0]    r_fi, w_fi, fi, last_fi;
   logic [MB_W-1:0]           mul_b;
   logic [MP_W-1:0]           mul_p;
   logic signed [2*SV_W-1:0]  sqx, sqy;
   logic [ADDR_W-1:0]         tap_addr, pix_addr, req_addr;
   logic [IDX_W-1:0]          idx_ext;
   logic                      in_range, req_fire, zero_geom, scan_last;
   logic [31:0]               d_wide;
   logic [WEIGHT_W-1:0]       rom_w;
   logic [PIXEL_W-1:0]        blur_value;

   // ram ports
   logic               ram_we;
   logic [ADDR_W-1:0]  ram_waddr, ram_raddr;
   logic [PIXEL_W-1:0] ram_wdata, ram_rdata;

   // ---------------------------------------------------------------------------
   // configuration registers, written any time
   // ---------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
         chan_ff   <= CHANNELS_RESET;
         radius_ff <= RADIUS_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_WIDTH:    width_ff  <= csr_write_data;
            CSR_HEIGHT:   height_ff <= csr_write_data;
            CSR_CHANNELS: chan_ff   <= csr_write_data[CHANNELS_W-1:0];
            CSR_RADIUS:   radius_ff <= csr_write_data[RADIUS_CFG_W-1:0];
         endcase
      end
   end

   // geometry saturated to what the store can hold
   assign eff_w = (32'(width_ff) > MAX_WIDTH) ? EW_W'(MAX_WIDTH) : EW_W'(width_ff);
   assign eff_h = (32'(height_ff) > MAX_HEIGHT) ? EH_W'(MAX_HEIGHT) : EH_W'(height_ff);
   assign eff_r = (32'(radius_ff) > MAX_RADIUS) ? R_W'(MAX_RADIUS) : R_W'(radius_ff);
   assign zero_geom = (eff_w == '0) || (eff_h == '0);

   assign r_s     = $signed({1'b0, eff_r});
   assign r_fi    = $signed(FI_W'(eff_r));
   assign w_fi    = $signed(FI_W'(eff_w));
   assign last_fi = $signed(FI_W'(last_ff));

   // request decode
   assign req_stall = (state_ff != S_IDLE) || (rsp_valid_ff && rsp_stall);
   assign req_fire  = req_valid && !req_stall;
   assign idx_ext   = IDX_W'(req_pixel_index);
   assign req_addr  = idx_ext[ADDR_W-1:0];
   assign in_range  = 32'(req_pixel_index) < STORE_DEPTH;

   // one shared multiplier: w*h first, then r*w
   assign mul_b = (state_ff == S_MUL_AREA) ? MB_W'(eff_h) : MB_W'(eff_r);
   assign mul_p = MP_W'(eff_w) * MP_W'(mul_b);

   // flat window index, clamped to the image
   assign fi = row_ff + col_ff;
   always_comb begin
      priority if (fi[FI_W-1]) begin
         tap_addr = '0;
      end else if (fi > last_fi) begin
         tap_addr = last_ff;
      end else begin
         tap_addr = fi[ADDR_W-1:0];
      end
   end

   // squared distance for the weight table
   assign sqx       = sx_ff * sx_ff;
   assign sqy       = sy_ff * sy_ff;
   assign scan_last = (sx_ff == r_s) && (sy_ff == r_s);

   assign pix_addr   = ybase_ff + ADDR_W'(x_ff);
   assign blur_value = (den_ff == '0) ? '0 : quo_ff;

   // ---------------------------------------------------------------------------
   // sequencer
   // ---------------------------------------------------------------------------
   always_comb begin
      state_in    = state_ff;
      rd_oob_in   = rd_oob_ff;
      x_in        = x_ff;
      y_in        = y_ff;
      ybase_in    = ybase_ff;
      last_in     = last_ff;
      rw_in       = rw_ff;
      sx_in       = sx_ff;
      sy_in       = sy_ff;
      row_in      = row_ff;
      col_in      = col_ff;
      num_in      = num_ff;
      den_in      = den_ff;
      acc_done_in = acc_done_ff;
      rem_in      = rem_ff;
      dsr_in      = dsr_ff;
      quo_in      = quo_ff;
      div_cnt_in  = div_cnt_ff;
      rsp_load    = 1'b0;
      rsp_new     = '0;
      ram_we      = 1'b0;
      ram_waddr   = req_addr;
      ram_wdata   = req_pixel_value;
      ram_raddr   = req_addr;

      // accumulate stage of the tap pipe
      if (c_valid_ff) begin
         num_in = num_ff + NUM_W'(c_prod_ff);
         den_in = den_ff + DEN_W'(c_w_ff);
         if (c_last_ff) begin
            acc_done_in = 1'b1;
         end
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               unique case (req_action)
                  ACT_LOAD: begin
                     ram_we   = in_range;
                     rsp_load = 1'b1;
                     rsp_new  = req_pixel_value;
                  end
                  ACT_READ: begin
                     rd_oob_in = !in_range;
                     state_in  = S_READ;
                  end
                  default: begin
                     // run, and the unused action that answers like one
                     if ((req_action == ACT_RUN) && !zero_geom) begin
                        x_in     = '0;
                        y_in     = '0;
                        ybase_in = '0;
                        state_in = S_MUL_AREA;
                     end else begin
                        rsp_load = 1'b1;
                     end
                  end
               endcase
            end
         end
         S_READ: begin
            rsp_load = 1'b1;
            rsp_new  = rd_oob_ff ? '0 : ram_rdata;
            state_in = S_IDLE;
         end
         S_MUL_AREA: begin
            last_in  = ADDR_W'(mul_p - MP_W'(1));
            state_in = S_MUL_RAD;
         end
         S_MUL_RAD: begin
            rw_in    = FI_W'(mul_p);
            state_in = S_WINDOW;
         end
         S_WINDOW: begin
            sx_in    = -r_s;
            sy_in    = -r_s;
            row_in   = $signed(FI_W'(ybase_ff)) - rw_ff;
            col_in   = $signed(FI_W'(x_ff)) - r_fi;
            num_in   = '0;
            den_in   = '0;
            state_in = S_SCAN;
         end
         S_SCAN: begin
            ram_raddr = tap_addr;
            if (sx_ff == r_s) begin
               sx_in  = -r_s;
               col_in = $signed(FI_W'(x_ff)) - r_fi;
               sy_in  = sy_ff + SV_W'(1);
               row_in = row_ff + w_fi;
            end else begin
               sx_in  = sx_ff + SV_W'(1);
               col_in = col_ff + FI_W'(1);
            end
            if (scan_last) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            if (acc_done_ff) begin
               acc_done_in = 1'b0;
               rem_in      = num_ff;
               dsr_in      = NUM_W'(den_ff) << (PIXEL_W - 1);
               quo_in      = '0;
               div_cnt_in  = DIV_CNT_W'(PIXEL_W - 1);
               state_in    = S_DIVIDE;
            end
         end
         S_DIVIDE: begin
            // restoring division, one quotient bit per cycle
            if (rem_ff >= dsr_ff) begin
               rem_in = rem_ff - dsr_ff;
               quo_in = {quo_ff[PIXEL_W-2:0], 1'b1};
            end else begin
               quo_in = {quo_ff[PIXEL_W-2:0], 1'b0};
            end
            dsr_in     = dsr_ff >> 1;
            div_cnt_in = div_cnt_ff - DIV_CNT_W'(1);
            if (div_cnt_ff == '0) begin
               state_in = S_WRITE;
            end
         end
         S_WRITE: begin
            ram_we    = 1'b1;
            ram_waddr = pix_addr;
            ram_wdata = blur_value;
            state_in  = S_WINDOW;
            if (x_ff == EW_W'(eff_w - EW_W'(1))) begin
               x_in = '0;
               if (y_ff == EH_W'(eff_h - EH_W'(1))) begin
                  // whole image done, answer the run word
                  rsp_load = 1'b1;
                  state_in = S_IDLE;
               end else begin
                  y_in     = y_ff + EH_W'(1);
                  ybase_in = ybase_ff + ADDR_W'(eff_w);
               end
            end else begin
               x_in = x_ff + EW_W'(1);
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         acc_done_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         acc_done_ff <= acc_done_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_oob_ff  <= rd_oob_in;
      x_ff       <= x_in;
      y_ff       <= y_in;
      ybase_ff   <= ybase_in;
      last_ff    <= last_in;
      rw_ff      <= rw_in;
      sx_ff      <= sx_in;
      sy_ff      <= sy_in;
      row_ff     <= row_in;
      col_ff     <= col_in;
      num_ff     <= num_in;
      den_ff     <= den_in;
      rem_ff     <= rem_in;
      dsr_ff     <= dsr_in;
      quo_ff     <= quo_in;
      div_cnt_ff <= div_cnt_in;
   end

   // ---------------------------------------------------------------------------
   // tap pipeline: ram fetch / weight lookup / multiply
   // ---------------------------------------------------------------------------
   assign d_wide = 32'(d_ff);
   assign rom_w  = (d_wide < WROM_DEPTH) ? WEIGHT_ROM[d_wide[WROM_IDX_W-1:0]] : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= (state_ff == S_SCAN);
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      a_last_ff <= scan_last;
      d_ff      <= D_W'(sqx) + D_W'(sqy);
      b_last_ff <= a_last_ff;
      b_val_ff  <= ram_rdata;
      b_w_ff    <= rom_w;
      c_last_ff <= b_last_ff;
      // zero pixels add nothing to either sum
      c_prod_ff <= PROD_W'(b_val_ff) * PROD_W'(b_w_ff);
      c_w_ff    <= (b_val_ff == '0) ? '0 : b_w_ff;
   end

   // ---------------------------------------------------------------------------
   // pixel store
   // ---------------------------------------------------------------------------
   zsgb_ram #(
      .WIDTH (PIXEL_W),
      .DEPTH (STORE_DEPTH)
   ) u_pixel_store (
      .clock         (clock),
      .write_enable  (ram_we),
      .write_address (ram_waddr),
      .write_data    (ram_wdata),
      .read_address  (ram_raddr),
      .read_data     (ram_rdata)
   );

   // ---------------------------------------------------------------------------
   // output register
   // ---------------------------------------------------------------------------
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_value_ff <= rsp_new;
         rsp_alpha_ff <= (chan_ff == FOUR_CHANNELS) ? ALPHA_OPAQUE : rsp_new;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = rsp_value_ff;
   assign rsp_result_alpha = rsp_alpha_ff;

endmodule

[hw/rtl/zsgb_checker.sv]
// ----------------------------------------------------------------------------
// zsgb_checker
// port-level checks of the blur block, bound to the top level
// ----------------------------------------------------------------------------
`include "zero_skipping_gaussian_blur_macros.svh"

module zsgb_checker
   import zsgb_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_stall,
   input logic [ACTION_W-1:0] req_action,
   input logic [PIXEL_W-1:0]  req_pixel_value,
   input logic                rsp_valid,
   input logic                rsp_stall,
   input logic [PIXEL_W-1:0]  rsp_result_value,
   input logic [PIXEL_W-1:0]  rsp_result_alpha
);

   // a stalled result word holds
   `ZSGB_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_result_value) && $stable(rsp_result_alpha), "stalled result word changed")

   // a loaded byte is echoed in the next cycle
   `ZSGB_ASSERT_NEXT(a_load_echo, clock, reset, req_valid && !req_stall && (req_action == ACT_LOAD), rsp_valid && (rsp_result_value == $past(req_pixel_value)), "load word not echoed")

   // no new word is taken while a result word waits
   `ZSGB_ASSERT_IMPLY(a_one_in_flight, clock, reset, rsp_valid && rsp_stall, req_stall, "request taken while result stalled")

   // alpha is opaque or follows the value
   `ZSGB_ASSERT_IMPLY(a_alpha_rule, clock, reset, rsp_valid, (rsp_result_alpha == ALPHA_OPAQUE) || (rsp_result_alpha == rsp_result_value), "alpha neither opaque nor value")

endmodule

bind zero_skipping_gaussian_blur zsgb_checker u_zsgb_checker (.*);

[tb/tb_zero_skipping_gaussian_blur.sv]
// ----------------------------------------------------------------------------
// tb_zero_skipping_gaussian_blur
// self-checking bench for the in-place zero-skipping gaussian blur
// ----------------------------------------------------------------------------
// Keeps its own copy of the image store and of the four registers, and works
// out the answer word for every request word as it is accepted. A short
// stimulus table walks the field extremes, every action, the empty window,
// zero geometry and four-channel alpha. Random phases follow: each one
// programs a geometry, loads every pixel of the image, then mixes loads,
// reads, blur passes and the spare action. Large images get small windows
// to keep a pass short. The sender idles in bursts and the receiver
// stalls in stretches of changing character.
// ----------------------------------------------------------------------------
module tb_zero_skipping_gaussian_blur;
   import zsgb_pkg::*;

   // geometry of the block as built here
   localparam int IMG_MAX_W       = 256;
   localparam int IMG_MAX_H       = 256;
   localparam int IMG_MAX_R       = 15;
   localparam int IMG_STORE_DEPTH = IMG_MAX_W * IMG_MAX_H;
   localparam int WEIGHT_TAPS     = 2 * IMG_MAX_R * IMG_MAX_R + 1;

   // exp(-1/32) in q0.32, the decay per unit of squared distance
   localparam longint unsigned EXP_DECAY_Q32 = 64'd4162825044;

   // action code that the block leaves unused
   localparam logic [ACTION_W-1:0] ACT_SPARE = 2'd3;

   localparam int RANDOM_WORDS = 1000;
   localparam int MAX_RUNS     = 60;
   localparam int DRAIN_LIMIT  = 100000;
   localparam int NUM_ROWS     = 33;

   typedef struct packed {
      logic [PIXEL_W-1:0] value;
      logic [PIXEL_W-1:0] alpha;
   } pixel_word_t;

   typedef enum logic {ROW_CFG, ROW_WORD} row_kind_t;

   typedef struct packed {
      row_kind_t                kind;
      logic [ACTION_W-1:0]      action;
      logic [PIXEL_INDEX_W-1:0] index;
      logic [PIXEL_W-1:0]       value;
      logic                     checked;   // expected word typed in below
      logic [PIXEL_W-1:0]       exp_value;
      logic [PIXEL_W-1:0]       exp_alpha;
      logic [CSR_INDEX_W-1:0]   reg_index;
      logic [CFG_W-1:0]         reg_data;
   } dir_row_t;

   typedef enum logic [1:0] {GEOM_STRIP, GEOM_COLUMN, GEOM_EMPTY, GEOM_SMALL} geometry_kind_t;
   typedef enum logic [1:0] {STALL_NONE, STALL_COIN, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

   // directed words: field extremes, every action, the special cases
   localparam dir_row_t DIRECTED [NUM_ROWS] = '{
      // three-pixel strip, radius one, single channel
      '{ROW_CFG,  ACT_LOAD,  16'd0,     8'd0,   1'b0, 8'd0,   8'd0,   CSR_WIDTH,    9'd3},
      '{ROW_CFG,  ACT_LOAD,  16'd0,     8'd0,   1'b0, 8'd0,   8'd0,   CSR_HEIGHT,   9'd1},
      '{ROW_CFG,  ACT_LOAD,  16'd0,     8'd0,   1'b0, 8'd0,   8'd0,   CSR_CHANNELS, 9'd1},
      '{ROW_CFG,  ACT_LOAD,  16'd0,     8'd0,   1'b0, 8'd0,   8'd0,   CSR_RADIUS,   9'd1},
      // loads echo their byte, lowest and highest index
      '{ROW_WORD, ACT_LOAD,  16'd0,     8'd0,   1'b1, 8'd0,   8'd0,   CSR_WIDTH,    9'd0},
      '{ROW_WORD, ACT_LOAD,  16'd1,     8'd255, 1'b1, 8'd255, 8'd255, CSR_WIDTH,    9'd0},
      '{ROW_WORD, ACT_LOAD,  16'd2,     8'd1,   1'b1, 8'd1,   8'd1,   CSR_WIDTH,    9'd0},
      '{ROW_WORD, ACT_LOAD,  16'd65535, 8'd170, 1'b1, 8'd170, 8'd170, CSR_WIDTH,    9'd0},
      '{ROW_WORD, ACT_LOAD,  16'd21845, 8'd85,  1'b1, 8'd85,  8'd85,  CSR_WIDTH,    9'd0},
      '{ROW_WORD, ACT_READ,  16'd65535, 8'd0,   1'b1, 8'd170, 8'd170, CSR_WIDTH,    9'd0},
      '{ROW_WORD, ACT_READ,  16'd2,     8'd0,   1'b1, 8'd1,   8'd1,   CSR_WIDTH,    9'd0},
      // a run answers zero, then the blurred strip is read back
      '{ROW_WORD, ACT_RUN,   16'd0,     8'd0,   1'b1, 8'd0,   8'd0,   CSR_WIDTH,    9'd0},
      '{ROW_WORD, ACT_READ,  16'd0,     8'd0,   1'b0, 8'd0,   8'd0,   CSR_WIDTH,    9'd0},
      '{ROW_WORD, ACT_READ,  16'd1,     8'd0,   1'b0, 8'd0,   8'd0,   CSR_WIDTH,    9'd0},
      '{ROW_WORD, ACT_READ,  16'd2,     8'd0,   1'b0, 8'd0,   8'd0,   CSR_WIDTH,    9'd0},
      // four channels force alpha, spare action answers like a run
      '{ROW_CFG,  ACT_LOAD,  16'd0,     8'd0,   1'b0, 8'd0,   8'd0,   CSR_CHANNELS, 9'd4},
      '{ROW_WORD, ACT_READ,  16'd21845, 8'd0,   1'b1, 8'd85,  8'd255, CSR_WIDTH,    9'd0},
      '{ROW_WORD, ACT_SPARE, 16'd43690, 8'd170, 1'b1, 8'd0,   8'd255, CSR_WIDTH,    9'd0},
      // zero width: the run leaves the image alone
      '{ROW_CFG,  ACT_LOAD,  16'd0,     8'd0,   1'b0, 8'd0,   8'd0,   CSR_WIDTH,    9'd0},
      '{ROW_WORD, ACT_RUN,   16'd0,     8'd0,   1'b1, 8'd0,   8'd255, CSR_WIDTH,    9'd0},
      '{ROW_WORD, ACT_READ,  16'd1,     8'd0,   1'b0, 8'd0,   8'd0,   CSR_WIDTH,    9'd0},
      // all-zero window at full radius blurs to zero
      '{ROW_CFG,  ACT_LOAD,  16'd0,     8'd0,   1'b0, 8'd0,   8'd0,   CSR_WIDTH,    9'd2},
      '{ROW_CFG,  ACT_LOAD,  16'd0,     8'd0,   1'b0, 8'd0,   8'd0,   CSR_CHANNELS, 9'd1},
      '{ROW_CFG,  ACT_LOAD,  16'd0,     8'd0,   1'b0, 8'd0,   8'd0,   CSR_RADIUS,   9'd15},
      '{ROW_WORD, ACT_LOAD,  16'd0,     8'd0,   1'b1, 8'd0,   8'd0,   CSR_WIDTH,    9'd0},
      '{ROW_WORD, ACT_LOAD,  16'd1,     8'd0,   1'b1, 8'd0,   8'd0,   CSR_WIDTH,    9'd0},
      '{ROW_WORD, ACT_RUN,   16'd0,     8'd0,   1'b1, 8'd0,   8'd0,   CSR_WIDTH,    9'd0},
      '{ROW_WORD, ACT_READ,  16'd1,     8'd0,   1'b1, 8'd0,   8'd0,   CSR_WIDTH,    9'd0},
      '{ROW_WORD, ACT_READ,  16'd0,     8'd0,   1'b1, 8'd0,   8'd0,   CSR_WIDTH,    9'd0},
      // zero height: again nothing moves
      '{ROW_CFG,  ACT_LOAD,  16'd0,     8'd0,   1'b0, 8'd0,   8'd0,   CSR_HEIGHT,   9'd0},
      '{ROW_CFG,  ACT_LOAD,  16'd0,     8'd0,   1'b0, 8'd0,   8'd0,   CSR_WIDTH,    9'd3},
      '{ROW_WORD, ACT_RUN,   16'd0,     8'd0,   1'b1, 8'd0,   8'd0,   CSR_WIDTH,    9'd0},
      '{ROW_WORD, ACT_READ,  16'd2,     8'd0,   1'b0, 8'd0,   8'd0,   CSR_WIDTH,    9'd0}
   };

   // ------------------------------------------------------------------------
   // dut signals, all known from time zero
   // ------------------------------------------------------------------------
   logic                     clock;
   logic                     reset            = 1'b1;
   logic                     req_valid        = 1'b0;
   logic                     req_stall;
   logic [ACTION_W-1:0]      req_action       = ACT_LOAD;
   logic [PIXEL_INDEX_W-1:0] req_pixel_index  = '0;
   logic [PIXEL_W-1:0]       req_pixel_value  = '0;
   logic                     rsp_valid;
   logic                     rsp_stall        = 1'b0;
   logic [PIXEL_W-1:0]       rsp_result_value;
   logic [PIXEL_W-1:0]       rsp_result_alpha;
   logic                     csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0]   csr_index        = CSR_WIDTH;
   logic [CFG_W-1:0]         csr_write_data   = '0;

   zero_skipping_gaussian_blur #(
      .MAX_WIDTH  (IMG_MAX_W),
      .MAX_HEIGHT (IMG_MAX_H),
      .MAX_RADIUS (IMG_MAX_R)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_action       (req_action),
      .req_pixel_index  (req_pixel_index),
      .req_pixel_value  (req_pixel_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_result_value (rsp_result_value),
      .rsp_result_alpha (rsp_result_alpha),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // ------------------------------------------------------------------------
   // image copy, register copy and the queue of words still owed
   // ------------------------------------------------------------------------
   logic [PIXEL_W-1:0]      image_copy [IMG_STORE_DEPTH];
   bit                      loaded     [IMG_STORE_DEPTH];
   int unsigned             loaded_list[$];
   logic [WEIGHT_W-1:0]     gauss_weight [WEIGHT_TAPS];
   logic [CFG_W-1:0]        cfg_width    = WIDTH_RESET;
   logic [CFG_W-1:0]        cfg_height   = HEIGHT_RESET;
   logic [CHANNELS_W-1:0]   cfg_channels = CHANNELS_RESET;
   logic [RADIUS_CFG_W-1:0] cfg_radius   = RADIUS_RESET;
   pixel_word_t             pending_pixels[$];

   int mismatch_count = 0;
   int results_checked = 0;
   int words_sent = 0;
   int loads_sent = 0;
   int reads_sent = 0;
   int runs_sent = 0;
   int spares_sent = 0;
   int burst_left = 0;

   // clock, period 4
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // gaussian weights in q0.16: exact q0.32 recurrence, rounded and saturated
   initial begin
      longint unsigned acc;
      longint unsigned rounded;
      int              d;
      acc = 64'd1 << 32;
      for (d = 0; d < WEIGHT_TAPS; d++) begin
         rounded = (acc + 64'd32768) >> 16;
         gauss_weight[d] = (rounded > 64'd65535) ? 16'hFFFF : rounded[WEIGHT_W-1:0];
         acc = (acc * EXP_DECAY_Q32 + (64'd1 << 31)) >> 32;
      end
   end

   // in-place raster blur of the image copy, zero pixels left out of the mean
   function automatic void blur_image_copy();
      int              w, h, r, last, x, y, sx, sy, fi;
      longint unsigned num, den, res;
      w = (cfg_width > IMG_MAX_W) ? IMG_MAX_W : int'(cfg_width);
      h = (cfg_height > IMG_MAX_H) ? IMG_MAX_H : int'(cfg_height);
      r = (cfg_radius > IMG_MAX_R) ? IMG_MAX_R : int'(cfg_radius);
      if (w == 0 || h == 0) return;
      last = w * h - 1;
      for (y = 0; y < h; y++) begin
         for (x = 0; x < w; x++) begin
            num = 0;
            den = 0;
            for (sy = -r; sy <= r; sy++) begin
               for (sx = -r; sx <= r; sx++) begin
                  // flat index, clamped to the image rather than per axis
                  fi = (y + sy) * w + (x + sx);
                  if (fi < 0) fi = 0;
                  if (fi > last) fi = last;
                  if (image_copy[fi] != '0) begin
                     num += longint'(image_copy[fi]) * longint'(gauss_weight[sx*sx + sy*sy]);
                     den += longint'(gauss_weight[sx*sx + sy*sy]);
                  end
               end
            end
            // an empty weight sum gives zero
            res = (den != 0) ? num / den : 0;
            if (res > 255) res = 255;
            image_copy[y * w + x] = res[PIXEL_W-1:0];
         end
      end
   endfunction

   // applies one accepted word to the copy and returns the word owed for it
   function automatic pixel_word_t process_word(input logic [ACTION_W-1:0]      act,
                                                input logic [PIXEL_INDEX_W-1:0] idx,
                                                input logic [PIXEL_W-1:0]       val);
      pixel_word_t owed;
      owed.value = '0;
      case (act)
         ACT_LOAD: begin
            image_copy[idx] = val;
            if (!loaded[idx]) begin
               loaded[idx] = 1'b1;
               loaded_list.push_back(idx);
            end
            owed.value = val;
         end
         ACT_RUN:  blur_image_copy();
         ACT_READ: owed.value = image_copy[idx];
         default:  ;   // spare action: nothing changes
      endcase
      owed.alpha = (cfg_channels == FOUR_CHANNELS) ? ALPHA_OPAQUE : owed.value;
      return owed;
   endfunction

   // pixel bytes lean on zero and the ends of the range
   function automatic logic [PIXEL_W-1:0] pixel_byte(input bit blank);
      if (blank) return '0;
      case ($urandom_range(0, 7))
         0, 1:    return '0;
         2:       return 8'd255;
         3:       return 8'd1;
         default: return PIXEL_W'($urandom);
      endcase
   endfunction

   // ------------------------------------------------------------------------
   // sender: bursts of words separated by random gaps
   // ------------------------------------------------------------------------
   // valid is only lowered when a real gap follows, so it never drops and
   // rises within one step; write_register lowers it before a register write
   task automatic send_word(input logic [ACTION_W-1:0]      act,
                            input logic [PIXEL_INDEX_W-1:0] idx,
                            input logic [PIXEL_W-1:0]       val,
                            input bit                       typed,
                            input pixel_word_t              typed_word);
      int          gap;
      pixel_word_t owed;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 8);
      end
      burst_left--;
      req_valid       <= 1'b1;
      req_action      <= act;
      req_pixel_index <= idx;
      req_pixel_value <= val;
      do @(posedge clock); while (req_stall);
      // accepted at this edge
      owed = process_word(act, idx, val);
      pending_pixels.push_back(typed ? typed_word : owed);
      words_sent++;
      case (act)
         ACT_LOAD: loads_sent++;
         ACT_READ: reads_sent++;
         ACT_RUN:  runs_sent++;
         default:  spares_sent++;
      endcase
   endtask

   // register write, only once the block has gone quiet
   task automatic write_register(input logic [CSR_INDEX_W-1:0] which,
                                 input logic [CFG_W-1:0]       data);
      req_valid <= 1'b0;
      burst_left = 0;
      while (pending_pixels.size() != 0) @(posedge clock);
      // every word answers, so a short pause covers the tail
      repeat (4) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= which;
      csr_write_data   <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      case (which)
         CSR_WIDTH:    cfg_width    = data;
         CSR_HEIGHT:   cfg_height   = data;
         CSR_CHANNELS: cfg_channels = data[CHANNELS_W-1:0];
         CSR_RADIUS:   cfg_radius   = data[RADIUS_CFG_W-1:0];
         default:      ;
      endcase
   endtask

   // ------------------------------------------------------------------------
   // receiver: stall in stretches, each with its own character
   // ------------------------------------------------------------------------
   initial begin
      stall_mode_t mode;
      int          stretch;
      int          beat;
      forever begin
         mode    = stall_mode_t'($urandom_range(0, 3));
         stretch = $urandom_range(20, 200);
         for (beat = 0; beat < stretch; beat++) begin
            @(posedge clock);
            case (mode)
               STALL_NONE:  rsp_stall <= 1'b0;
               STALL_COIN:  rsp_stall <= $urandom_range(0, 1);
               STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
               default:     rsp_stall <= ((beat % 7) < 4);
            endcase
         end
      end
   end

   // ------------------------------------------------------------------------
   // checker: every word taken is matched against the oldest one owed
   // ------------------------------------------------------------------------
   initial begin
      pixel_word_t want;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            if (pending_pixels.size() == 0) begin
               $display("%0t: unexpected word, expected none, actual value %0d alpha %0d",
                        $time, rsp_result_value, rsp_result_alpha);
               mismatch_count++;
            end else begin
               want = pending_pixels.pop_front();
               results_checked++;
               if (rsp_result_value !== want.value) begin
                  $display("%0t: result_value expected %0d actual %0d",
                           $time, want.value, rsp_result_value);
                  mismatch_count++;
               end
               if (rsp_result_alpha !== want.alpha) begin
                  $display("%0t: result_alpha expected %0d actual %0d",
                           $time, want.alpha, rsp_result_alpha);
                  mismatch_count++;
               end
            end
         end
      end
   end

   // hard stop well beyond the slowest run that this bench sends
   initial begin
      #20000000;
      $display("tb: failure");
      $finish;
   end

   // ------------------------------------------------------------------------
   // stimulus
   // ------------------------------------------------------------------------
   initial begin
      geometry_kind_t           kind;
      logic [CFG_W-1:0]         width;
      logic [CFG_W-1:0]         height;
      logic [RADIUS_CFG_W-1:0]  radius;
      logic [PIXEL_INDEX_W-1:0] idx;
      int                       eff_pixels;
      int                       random_goal;
      int                       phase_count;
      int                       phase_runs;
      int                       mixed;
      int                       pick;
      int                       p;
      int                       drain_cycles;
      bit                       blank;

      phase_count = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table
      for (int i = 0; i < NUM_ROWS; i++) begin
         if (DIRECTED[i].kind == ROW_CFG)
            write_register(DIRECTED[i].reg_index, DIRECTED[i].reg_data);
         else
            send_word(DIRECTED[i].action, DIRECTED[i].index, DIRECTED[i].value,
                      DIRECTED[i].checked, {DIRECTED[i].exp_value, DIRECTED[i].exp_alpha});
      end

      // random phases: program a geometry, fill the image, then mix words;
      // the first phases pin the wide, tall, empty and radius extremes
      random_goal = words_sent + RANDOM_WORDS;
      while (words_sent < random_goal) begin
         if (phase_count < 3)
            kind = geometry_kind_t'(phase_count);
         else if ($urandom_range(0, 15) < 3)
            kind = geometry_kind_t'($urandom_range(0, 2));
         else
            kind = GEOM_SMALL;
         case (kind)
            GEOM_STRIP: begin
               width  = (phase_count == 0) ? 9'd256 : CFG_W'($urandom_range(256, 511));
               height = 9'd1;
            end
            GEOM_COLUMN: begin
               width  = 9'd1;
               height = (phase_count == 1) ? 9'd511 : CFG_W'($urandom_range(256, 511));
            end
            GEOM_EMPTY: begin
               if ($urandom_range(0, 1) == 0) begin
                  width  = '0;
                  height = CFG_W'($urandom_range(0, 8));
               end else begin
                  width  = CFG_W'($urandom_range(1, 8));
                  height = '0;
               end
            end
            default: begin
               width  = CFG_W'($urandom_range(1, (phase_count < 5) ? 4 : 8));
               height = CFG_W'($urandom_range(1, (phase_count < 5) ? 4 : 8));
            end
         endcase
         eff_pixels = ((width > IMG_MAX_W) ? IMG_MAX_W : int'(width)) *
                      ((height > IMG_MAX_H) ? IMG_MAX_H : int'(height));
         // large images get small windows to keep a pass short
         if (eff_pixels > 64)      radius = RADIUS_CFG_W'($urandom_range(0, 3));
         else if (eff_pixels > 16) radius = RADIUS_CFG_W'($urandom_range(0, 7));
         else if (phase_count == 3) radius = 4'd15;
         else if (phase_count == 4) radius = 4'd0;
         else                       radius = RADIUS_CFG_W'($urandom_range(0, 15));

         write_register(CSR_WIDTH, width);
         write_register(CSR_HEIGHT, height);
         // upper data bits carry noise the register drops
         write_register(CSR_CHANNELS, CFG_W'($urandom_range(0, 511)));
         write_register(CSR_RADIUS, {5'($urandom), radius});

         // every pixel of the image is loaded before any pass can read it
         blank = ($urandom_range(0, 7) == 0);
         for (p = 0; p < eff_pixels; p++)
            send_word(ACT_LOAD, PIXEL_INDEX_W'(p), pixel_byte(blank), 1'b0, '0);

         mixed      = $urandom_range(10, 40);
         phase_runs = 0;
         repeat (mixed) begin
            pick = $urandom_range(0, 99);
            if (pick < 8 && phase_runs < 3 && runs_sent < MAX_RUNS) begin
               send_word(ACT_RUN, PIXEL_INDEX_W'($urandom), PIXEL_W'($urandom), 1'b0, '0);
               phase_runs++;
            end else if (pick < 12) begin
               send_word(ACT_SPARE, PIXEL_INDEX_W'($urandom), PIXEL_W'($urandom), 1'b0, '0);
            end else if (pick < 50) begin
               if (eff_pixels > 0 && $urandom_range(0, 2) != 0)
                  idx = PIXEL_INDEX_W'($urandom_range(0, eff_pixels - 1));
               else
                  idx = PIXEL_INDEX_W'($urandom_range(0, 65535));
               send_word(ACT_LOAD, idx, pixel_byte(blank), 1'b0, '0);
            end else begin
               // reads only touch entries that were written
               if (eff_pixels > 0 && $urandom_range(0, 1) == 0)
                  idx = PIXEL_INDEX_W'($urandom_range(0, eff_pixels - 1));
               else
                  idx = PIXEL_INDEX_W'(loaded_list[$urandom_range(0, loaded_list.size() - 1)]);
               send_word(ACT_READ, idx, PIXEL_W'($urandom), 1'b0, '0);
            end
         end
         phase_count++;
      end

      // drain, with a bound, then a short quiet tail for stray words
      req_valid <= 1'b0;
      drain_cycles = 0;
      while (pending_pixels.size() != 0 && drain_cycles < DRAIN_LIMIT) begin
         @(posedge clock);
         drain_cycles++;
      end
      if (pending_pixels.size() != 0) begin
         $display("%0t: %0d expected words never arrived", $time, pending_pixels.size());
         mismatch_count++;
      end
      repeat (20) @(posedge clock);

      $display("summary: %0d words sent (%0d loads, %0d reads, %0d blur passes, %0d spare)",
               words_sent, loads_sent, reads_sent, runs_sent, spares_sent);
      $display("summary: %0d geometry phases, %0d words checked, %0d mismatches",
               phase_count, results_checked, mismatch_count);
      if (mismatch_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
